// File: rtl/wss_pkg.sv
// ----------------------------------------------------------------------------
// wss_pkg
// Shared types, sizes, codes and ring arithmetic of the work-stealing
// task scheduler.
// ----------------------------------------------------------------------------
`default_nettype none

package wss_pkg;

    localparam int NUM_WORKERS = 16;
    localparam int QUEUE_DEPTH = 64;
    localparam int TASK_WIDTH  = 64;

    localparam int WID_W  = $clog2(NUM_WORKERS);
    localparam int WC_W   = $clog2(NUM_WORKERS + 1);
    localparam int POS_W  = $clog2(QUEUE_DEPTH);
    localparam int FILL_W = $clog2(QUEUE_DEPTH + 1);
    localparam int SUM_W  = FILL_W + 1;
    localparam int MEM_DEPTH = NUM_WORKERS * QUEUE_DEPTH;
    localparam int ADDR_W = $clog2(MEM_DEPTH);

    // fixed field widths
    localparam int FUNC_W   = 3;
    localparam int WORKER_W = 4;
    localparam int CFG_W    = 5;
    localparam int STAT_W   = 2;
    localparam int CNT_W    = 11;
    localparam int STEAL_W  = 32;

    localparam logic [CNT_W-1:0] INFLIGHT_MAX = '1;

    localparam logic [FUNC_W-1:0] FN_PUSH     = 3'd0;
    localparam logic [FUNC_W-1:0] FN_POP      = 3'd1;
    localparam logic [FUNC_W-1:0] FN_DONE     = 3'd2;
    localparam logic [FUNC_W-1:0] FN_BEGIN    = 3'd3;
    localparam logic [FUNC_W-1:0] FN_SHUTDOWN = 3'd4;
    localparam logic [FUNC_W-1:0] FN_TRY_SHUT = 3'd5;

    localparam logic [STAT_W-1:0] STAT_OK      = 2'd0;
    localparam logic [STAT_W-1:0] STAT_NO_WORK = 2'd1;
    localparam logic [STAT_W-1:0] STAT_REFUSED = 2'd2;
    localparam logic [STAT_W-1:0] STAT_FULL    = 2'd3;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_SCAN,
        S_READ,
        S_RESP
    } wss_state_t;

    typedef struct packed {
        logic             done;
        logic             found;
        logic [WID_W-1:0] victim;
    } wss_scan_res_t;

    // slot of entry 'off' counted from the front of a ring
    function automatic logic [POS_W-1:0] ring_pos(
        input logic [POS_W-1:0]  front,
        input logic [FILL_W-1:0] off
    );
        logic [SUM_W-1:0] sum;
        sum = SUM_W'(front) + SUM_W'(off);
        if (sum >= SUM_W'(QUEUE_DEPTH))
        begin
            sum = sum - SUM_W'(QUEUE_DEPTH);
        end
        return POS_W'(sum);
    endfunction

    function automatic logic [ADDR_W-1:0] store_addr(
        input logic [WID_W-1:0] w,
        input logic [POS_W-1:0] pos
    );
        return ADDR_W'(w) * ADDR_W'(QUEUE_DEPTH) + ADDR_W'(pos);
    endfunction

endpackage

`default_nettype wire

// File: rtl/wss_ram.sv
// ----------------------------------------------------------------------------
// wss_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module wss_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 1024
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

// File: rtl/wss_scan.sv
// ----------------------------------------------------------------------------
// wss_scan
// Victim scanner: walks the other active workers in cyclic order, one
// non-empty test per cycle, and reports the first queue holding work.
// ----------------------------------------------------------------------------
`default_nettype none

module wss_scan (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           start,
    input  wire logic [wss_pkg::WID_W-1:0]      worker,
    input  wire logic [wss_pkg::WC_W-1:0]       active,
    input  wire logic [wss_pkg::NUM_WORKERS-1:0] nonempty,
    output wss_pkg::wss_scan_res_t              res
);

    logic                      busy_reg,  busy_next;
    logic [wss_pkg::WID_W-1:0] cand_reg,  cand_next;
    logic [wss_pkg::WC_W-1:0]  left_reg,  left_next;
    logic                      hit;

    // next candidate after w, wrapping at the active count (w < active)
    function automatic logic [wss_pkg::WID_W-1:0] next_cand(
        input logic [wss_pkg::WID_W-1:0] w,
        input logic [wss_pkg::WC_W-1:0]  n
    );
        logic [wss_pkg::WC_W-1:0] sum;
        sum = wss_pkg::WC_W'(w) + wss_pkg::WC_W'(1);
        if (sum >= n)
        begin
            sum = '0;
        end
        return wss_pkg::WID_W'(sum);
    endfunction

    assign hit        = nonempty[cand_reg];
    assign res.found  = busy_reg && hit;
    assign res.done   = busy_reg && (hit || left_reg == wss_pkg::WC_W'(1));
    assign res.victim = cand_reg;

    always_comb
    begin
        busy_next = busy_reg;
        cand_next = cand_reg;
        left_next = left_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cand_next = next_cand(worker, active);
            left_next = active - wss_pkg::WC_W'(1);
        end
        else if (busy_reg)
        begin
            if (res.done)
            begin
                busy_next = 1'b0;
            end
            else
            begin
                cand_next = next_cand(cand_reg, active);
                left_next = left_reg - wss_pkg::WC_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cand_reg <= '0;
            left_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cand_reg <= cand_next;
            left_reg <= left_next;
        end
    end

endmodule

`default_nettype wire

// File: rtl/work_stealing_task_scheduler_core.sv
// Each transaction passes from IDLE through EXEC to RESP: push, counter and shutdown
// operations and pops that are refused or find nothing with one worker go straight to RESP,
// a pop from the worker's own queue passes READ, and a steal passes SCAN, where the victim
// scanner tests k (1 .. n-1) queues, one per cycle, n being the active worker count, then READ
// if it found work. One item is in work at a time; the next is taken the cycle after the
// result transaction. Reset clears all queue pointers, counters and the shutdown flag at once.
// ----------------------------------------------------------------------------
// work_stealing_task_scheduler_core
// Per-worker task deques in a shared task RAM, with LIFO pop, cyclic
// front-steal, in-flight accounting, shutdown detection and statistics.
// ----------------------------------------------------------------------------
`default_nettype none

module work_stealing_task_scheduler_core (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         cfg_wr_en,
    input  wire logic [4:0]   cfg_wr_data,    // active worker count
    input  wire logic         s_tvalid,
    output logic              s_tready,
    input  wire logic [71:0]  s_tdata,        // worker[3:0], task word[67:4]
    input  wire logic [2:0]   s_tuser,        // func[2:0]
    output logic              m_tvalid,
    input  wire logic         m_tready,
    // status[1:0], task_out[65:2], was_stolen[66], source_worker[70:67],
    // queued_total[81:71], in_flight_total[92:82], peak_queued[103:93],
    // steal_tries[135:104], steal_wins[167:136], is_shut[168], is_idle_now[169]
    output logic [175:0]      m_tdata
);

    localparam int WID_W  = wss_pkg::WID_W;
    localparam int WC_W   = wss_pkg::WC_W;
    localparam int POS_W  = wss_pkg::POS_W;
    localparam int FILL_W = wss_pkg::FILL_W;
    localparam int CNT_W  = wss_pkg::CNT_W;
    localparam int NW     = wss_pkg::NUM_WORKERS;

    wss_pkg::wss_state_t state_reg, state_next;

    logic [wss_pkg::CFG_W-1:0]   workers_cfg_reg;
    logic [POS_W-1:0]            front_reg [NW];
    logic [POS_W-1:0]            front_next [NW];
    logic [FILL_W-1:0]           fill_reg [NW];
    logic [FILL_W-1:0]           fill_next [NW];
    logic [CNT_W-1:0]            queued_reg,   queued_next;
    logic [CNT_W-1:0]            inflight_reg, inflight_next;
    logic [CNT_W-1:0]            peak_reg,     peak_next;
    logic [wss_pkg::STEAL_W-1:0] tries_reg,    tries_next;
    logic [wss_pkg::STEAL_W-1:0] wins_reg,     wins_next;
    logic                        shut_reg,     shut_next;

    // latched transaction and result
    logic [wss_pkg::FUNC_W-1:0]     func_reg, func_next;
    logic [WID_W-1:0]               wid_reg,  wid_next;
    logic [WC_W-1:0]                wc_reg,   wc_next;
    logic [wss_pkg::TASK_WIDTH-1:0] data_reg, data_next;
    logic [wss_pkg::STAT_W-1:0]     status_reg, status_next;
    logic [wss_pkg::TASK_WIDTH-1:0] task_reg,   task_next;
    logic                           stolen_reg, stolen_next;
    logic [WID_W-1:0]               src_reg,    src_next;

    logic [WC_W-1:0]  wc_eff;
    logic [WID_W-1:0] wid_in;
    logic [NW-1:0]    nonempty;
    logic             idle_now;
    logic             pop_refused;
    logic             own_has;
    logic             can_steal;
    logic             scan_start;
    wss_pkg::wss_scan_res_t scan_res;

    logic                           ram_we, ram_re;
    logic [wss_pkg::ADDR_W-1:0]     ram_waddr, ram_raddr;
    logic [wss_pkg::TASK_WIDTH-1:0] ram_rdata;
    logic [CNT_W-1:0]               queued_inc;

    always_comb
    begin
        if (workers_cfg_reg == '0)
        begin
            wc_eff = WC_W'(1);
        end
        else if (WC_W'(workers_cfg_reg) > WC_W'(NW))
        begin
            wc_eff = WC_W'(NW);
        end
        else
        begin
            wc_eff = WC_W'(workers_cfg_reg);
        end
        wid_in = WID_W'(s_tdata[3:0]);
        if (WC_W'(s_tdata[3:0]) >= wc_eff)
        begin
            wid_in = WID_W'(wc_eff - WC_W'(1));
        end
    end

    always_comb
    begin
        for (int i = 0; i < NW; i++)
        begin
            nonempty[i] = fill_reg[i] != '0;
        end
    end

    assign idle_now    = queued_reg == '0 && inflight_reg == '0;
    assign pop_refused = shut_reg && idle_now;
    assign own_has     = fill_reg[wid_reg] != '0;
    assign can_steal   = wc_reg > WC_W'(1);
    assign queued_inc  = queued_reg + CNT_W'(1);

    wss_scan u_scan (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (scan_start),
        .worker   (wid_reg),
        .active   (wc_reg),
        .nonempty (nonempty),
        .res      (scan_res)
    );

    wss_ram #(
        .WIDTH (wss_pkg::TASK_WIDTH),
        .DEPTH (wss_pkg::MEM_DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (data_reg),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            wss_pkg::S_IDLE:
            begin
                if (s_tvalid)
                begin
                    state_next = wss_pkg::S_EXEC;
                end
            end
            wss_pkg::S_EXEC:
            begin
                state_next = wss_pkg::S_RESP;
                if (func_reg == wss_pkg::FN_POP && !pop_refused)
                begin
                    if (own_has)
                    begin
                        state_next = wss_pkg::S_READ;
                    end
                    else if (can_steal)
                    begin
                        state_next = wss_pkg::S_SCAN;
                    end
                end
            end
            wss_pkg::S_SCAN:
            begin
                if (scan_res.done)
                begin
                    state_next = scan_res.found ? wss_pkg::S_READ : wss_pkg::S_RESP;
                end
            end
            wss_pkg::S_READ:
            begin
                state_next = wss_pkg::S_RESP;
            end
            wss_pkg::S_RESP:
            begin
                if (m_tready)
                begin
                    state_next = wss_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = wss_pkg::S_IDLE;
            end
        endcase
    end

    // datapath and outputs
    always_comb
    begin
        front_next    = front_reg;
        fill_next     = fill_reg;
        queued_next   = queued_reg;
        inflight_next = inflight_reg;
        peak_next     = peak_reg;
        tries_next    = tries_reg;
        wins_next     = wins_reg;
        shut_next     = shut_reg;
        func_next     = func_reg;
        wid_next      = wid_reg;
        wc_next       = wc_reg;
        data_next     = data_reg;
        status_next   = status_reg;
        task_next     = task_reg;
        stolen_next   = stolen_reg;
        src_next      = src_reg;
        ram_we        = 1'b0;
        ram_re        = 1'b0;
        ram_waddr     = wss_pkg::store_addr(wid_reg,
                            wss_pkg::ring_pos(front_reg[wid_reg], fill_reg[wid_reg]));
        ram_raddr     = '0;
        scan_start    = 1'b0;
        s_tready      = state_reg == wss_pkg::S_IDLE;
        m_tvalid      = state_reg == wss_pkg::S_RESP;

        case (state_reg)
            wss_pkg::S_IDLE:
            begin
                if (s_tvalid)
                begin
                    func_next   = s_tuser;
                    wid_next    = wid_in;
                    wc_next     = wc_eff;
                    data_next   = s_tdata[67:4];
                    status_next = wss_pkg::STAT_OK;
                    task_next   = '0;
                    stolen_next = 1'b0;
                    src_next    = '0;
                end
            end
            wss_pkg::S_EXEC:
            begin
                case (func_reg)
                    wss_pkg::FN_PUSH:
                    begin
                        if (shut_reg)
                        begin
                            status_next = wss_pkg::STAT_REFUSED;
                        end
                        else if (fill_reg[wid_reg] == FILL_W'(wss_pkg::QUEUE_DEPTH))
                        begin
                            status_next = wss_pkg::STAT_FULL;
                        end
                        else
                        begin
                            ram_we             = 1'b1;
                            fill_next[wid_reg] = fill_reg[wid_reg] + FILL_W'(1);
                            queued_next        = queued_inc;
                            if (queued_inc > peak_reg)
                            begin
                                peak_next = queued_inc;
                            end
                        end
                    end
                    wss_pkg::FN_POP:
                    begin
                        if (pop_refused)
                        begin
                            status_next = wss_pkg::STAT_REFUSED;
                        end
                        else if (own_has)
                        begin
                            // LIFO from the back of the own queue
                            ram_re    = 1'b1;
                            ram_raddr = wss_pkg::store_addr(wid_reg,
                                wss_pkg::ring_pos(front_reg[wid_reg],
                                                  fill_reg[wid_reg] - FILL_W'(1)));
                            fill_next[wid_reg] = fill_reg[wid_reg] - FILL_W'(1);
                            src_next      = wid_reg;
                            queued_next   = queued_reg - CNT_W'(1);
                            if (inflight_reg != wss_pkg::INFLIGHT_MAX)
                            begin
                                inflight_next = inflight_reg + CNT_W'(1);
                            end
                        end
                        else if (can_steal)
                        begin
                            tries_next = tries_reg + wss_pkg::STEAL_W'(1);
                            scan_start = 1'b1;
                        end
                        else
                        begin
                            status_next = wss_pkg::STAT_NO_WORK;
                            if (idle_now)
                            begin
                                shut_next = 1'b1;
                            end
                        end
                    end
                    wss_pkg::FN_DONE:
                    begin
                        if (inflight_reg != '0)
                        begin
                            inflight_next = inflight_reg - CNT_W'(1);
                        end
                    end
                    wss_pkg::FN_BEGIN:
                    begin
                        if (inflight_reg != wss_pkg::INFLIGHT_MAX)
                        begin
                            inflight_next = inflight_reg + CNT_W'(1);
                        end
                    end
                    wss_pkg::FN_SHUTDOWN:
                    begin
                        shut_next = 1'b1;
                    end
                    wss_pkg::FN_TRY_SHUT:
                    begin
                        if (shut_reg || !idle_now)
                        begin
                            status_next = wss_pkg::STAT_REFUSED;
                        end
                        else
                        begin
                            shut_next = 1'b1;
                        end
                    end
                    default:
                    begin
                        status_next = wss_pkg::STAT_REFUSED;
                    end
                endcase
            end
            wss_pkg::S_SCAN:
            begin
                if (scan_res.done)
                begin
                    if (scan_res.found)
                    begin
                        // steal from the front of the victim queue
                        ram_re    = 1'b1;
                        ram_raddr = wss_pkg::store_addr(scan_res.victim,
                                        front_reg[scan_res.victim]);
                        if (front_reg[scan_res.victim] == POS_W'(wss_pkg::QUEUE_DEPTH - 1))
                        begin
                            front_next[scan_res.victim] = '0;
                        end
                        else
                        begin
                            front_next[scan_res.victim] =
                                front_reg[scan_res.victim] + POS_W'(1);
                        end
                        fill_next[scan_res.victim] =
                            fill_reg[scan_res.victim] - FILL_W'(1);
                        wins_next   = wins_reg + wss_pkg::STEAL_W'(1);
                        stolen_next = 1'b1;
                        src_next    = scan_res.victim;
                        queued_next = queued_reg - CNT_W'(1);
                        if (inflight_reg != wss_pkg::INFLIGHT_MAX)
                        begin
                            inflight_next = inflight_reg + CNT_W'(1);
                        end
                    end
                    else
                    begin
                        status_next = wss_pkg::STAT_NO_WORK;
                        if (idle_now)
                        begin
                            shut_next = 1'b1;
                        end
                    end
                end
            end
            wss_pkg::S_READ:
            begin
                task_next = ram_rdata;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= wss_pkg::S_IDLE;
            workers_cfg_reg <= wss_pkg::CFG_W'(1);
            queued_reg      <= '0;
            inflight_reg    <= '0;
            peak_reg        <= '0;
            tries_reg       <= '0;
            wins_reg        <= '0;
            shut_reg        <= 1'b0;
            for (int i = 0; i < NW; i++)
            begin
                front_reg[i] <= '0;
                fill_reg[i]  <= '0;
            end
        end
        else
        begin
            state_reg    <= state_next;
            queued_reg   <= queued_next;
            inflight_reg <= inflight_next;
            peak_reg     <= peak_next;
            tries_reg    <= tries_next;
            wins_reg     <= wins_next;
            shut_reg     <= shut_next;
            front_reg    <= front_next;
            fill_reg     <= fill_next;
            if (cfg_wr_en)
            begin
                workers_cfg_reg <= cfg_wr_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        func_reg   <= func_next;
        wid_reg    <= wid_next;
        wc_reg     <= wc_next;
        data_reg   <= data_next;
        status_reg <= status_next;
        task_reg   <= task_next;
        stolen_reg <= stolen_next;
        src_reg    <= src_next;
    end

    assign m_tdata = {6'd0, idle_now, shut_reg, wins_reg, tries_reg, peak_reg,
                      inflight_reg, queued_reg, 4'(src_reg), stolen_reg,
                      task_reg, status_reg};

    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> !s_tready)
        else $error("input taken while a result is pending");

    a_peak_covers_queued: assert property (@(posedge clk) disable iff (!rst_n)
        peak_reg >= queued_reg)
        else $error("peak_queued below queued_total");

    a_victim_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == wss_pkg::S_SCAN && scan_res.found) |->
            (nonempty[scan_res.victim] && scan_res.victim != wid_reg))
        else $error("steal picked an empty or own queue");

    a_accept_exec: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> state_reg == wss_pkg::S_EXEC)
        else $error("accepted transaction not executed");

endmodule

`default_nettype wire
